FILE: rtl/ev_charge_pilot_sequencer_top_defines.svh
// ---------------------------------------------------------------------------
// ev charge pilot sequencer assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef EV_CHARGE_PILOT_SEQUENCER_TOP_DEFINES_SVH
`define EV_CHARGE_PILOT_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ECPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ECPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ecps_pkg.sv
// ---------------------------------------------------------------------------
// ecps_pkg
// codes, item types and control state for the charge pilot sequencer
// ---------------------------------------------------------------------------
package ecps_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		PL_12V = 2'd0,
		PL_9V  = 2'd1,
		PL_6V  = 2'd2,
		PL_ERR = 2'd3
	} pilot_t;

	typedef enum logic [2:0] {
		ST_READY    = 3'd0,
		ST_STARTING = 3'd1,
		ST_STARTOK  = 3'd2,
		ST_CHARGING = 3'd3,
		ST_FULL     = 3'd4,
		ST_STOPPING = 3'd5,
		ST_STOPOK   = 3'd6
	} state_t;

	typedef enum logic [2:0] {
		SC_NONE     = 3'd0,
		SC_READY    = 3'd1,
		SC_WORKING  = 3'd2,
		SC_FULL     = 3'd3,
		SC_FINISHED = 3'd4
	} status_t;

	// one accepted input item
	typedef struct packed {
		logic [1:0] opcode;
		logic       target_outlet;
		logic [1:0] pilot_level;
		logic       fault_undervoltage;
		logic       fault_overvoltage;
		logic       fault_any;
	} in_item_t;

	// sequencer control state
	typedef struct packed {
		state_t  seq;
		status_t status;
		logic    pwm;
		logic    relay;
	} ctl_t;

	// one result item
	typedef struct packed {
		logic [2:0] charge_state;
		logic [2:0] outlet_status;
		logic       pwm_enable;
		logic       relay_closed;
		logic       start_ok_pulse;
		logic       stop_done_pulse;
	} out_item_t;

endpackage

FILE: rtl/ecps_if.sv
// ---------------------------------------------------------------------------
// ecps channel interfaces
// valid/ready channels for input items and result items
// ---------------------------------------------------------------------------
interface ecps_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic       target_outlet;
	logic [1:0] pilot_level;
	logic       fault_undervoltage;
	logic       fault_overvoltage;
	logic       fault_any;

	modport source (
		output valid, opcode, target_outlet, pilot_level,
		output fault_undervoltage, fault_overvoltage, fault_any,
		input  ready
	);
	modport sink (
		input  valid, opcode, target_outlet, pilot_level,
		input  fault_undervoltage, fault_overvoltage, fault_any,
		output ready
	);
endinterface

interface ecps_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] charge_state;
	logic [2:0] outlet_status;
	logic       pwm_enable;
	logic       relay_closed;
	logic       start_ok_pulse;
	logic       stop_done_pulse;

	modport source (
		output valid, charge_state, outlet_status, pwm_enable, relay_closed,
		output start_ok_pulse, stop_done_pulse,
		input  ready
	);
	modport sink (
		input  valid, charge_state, outlet_status, pwm_enable, relay_closed,
		input  start_ok_pulse, stop_done_pulse,
		output ready
	);
endinterface

FILE: rtl/ecps_step.sv
// ---------------------------------------------------------------------------
// ecps_step
// next control state and pulses for one item
// ---------------------------------------------------------------------------
module ecps_step (
	input  ecps_pkg::in_item_t item,
	input  ecps_pkg::ctl_t     cur,
	output ecps_pkg::ctl_t     nxt,
	output logic               start_ok,
	output logic               stop_done
);
	import ecps_pkg::*;

	logic lost;
	logic supply_fault;

	assign lost         = (item.pilot_level == PL_12V) || (item.pilot_level == PL_ERR);
	assign supply_fault = item.fault_undervoltage | item.fault_overvoltage;

	// next state
	always_comb begin
		nxt = cur;
		unique case (item.opcode)
			OP_TICK: begin
				unique case (cur.seq)
					ST_STARTING: begin
						if (item.pilot_level == PL_6V || item.pilot_level == PL_9V) begin
							nxt.pwm    = 1'b1;
							nxt.seq    = ST_STARTOK;
							nxt.status = SC_READY;
						end else begin
							nxt.seq = ST_STOPPING;
						end
					end
					ST_STARTOK: begin
						if (item.pilot_level == PL_6V) begin
							nxt.relay  = 1'b1;
							nxt.seq    = ST_CHARGING;
							nxt.status = SC_WORKING;
						end else if (lost) begin
							nxt.seq = ST_STOPPING;
						end
					end
					ST_CHARGING: begin
						if (item.pilot_level == PL_9V) begin
							nxt.relay  = 1'b0;
							nxt.seq    = ST_FULL;
							nxt.status = SC_FULL;
						end
						if (lost) begin
							nxt.seq = ST_STOPPING;
						end
						// supply fault wins over the pilot
						if (supply_fault) begin
							nxt.relay  = 1'b0;
							nxt.seq    = ST_FULL;
							nxt.status = SC_FULL;
						end
					end
					ST_FULL: begin
						if (lost) begin
							nxt.seq = ST_STOPPING;
						end else if (!supply_fault && item.pilot_level == PL_6V) begin
							nxt.relay  = 1'b1;
							nxt.seq    = ST_CHARGING;
							nxt.status = SC_WORKING;
						end
					end
					ST_STOPPING: begin
						nxt.pwm   = 1'b0;
						nxt.relay = 1'b0;
						nxt.seq   = ST_STOPOK;
					end
					ST_STOPOK: begin
						nxt.status = SC_FINISHED;
						nxt.seq    = ST_READY;
					end
					default: begin
					end
				endcase
			end
			OP_START: begin
				if (!item.fault_any && cur.seq == ST_READY) begin
					nxt.seq = ST_STARTING;
				end
			end
			OP_STOP: begin
				if (cur.status != SC_NONE) begin
					nxt.seq = ST_STOPPING;
				end
			end
			default: begin
			end
		endcase
	end

	// pulses, ticks only
	always_comb begin
		start_ok  = (item.opcode == OP_TICK) && (cur.seq == ST_STARTOK) &&
			(item.pilot_level == PL_6V);
		stop_done = (item.opcode == OP_TICK) && (cur.seq == ST_STOPOK);
	end

endmodule

FILE: rtl/ecps_out_stage.sv
// ---------------------------------------------------------------------------
// ecps_out_stage
// result register in front of the output channel
// ---------------------------------------------------------------------------
module ecps_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ecps_pkg::out_item_t data,
	output logic                free,
	ecps_out_if.source          result
);
	import ecps_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign result.valid           = valid_q;
	assign result.charge_state    = data_q.charge_state;
	assign result.outlet_status   = data_q.outlet_status;
	assign result.pwm_enable      = data_q.pwm_enable;
	assign result.relay_closed    = data_q.relay_closed;
	assign result.start_ok_pulse  = data_q.start_ok_pulse;
	assign result.stop_done_pulse = data_q.stop_done_pulse;

endmodule

FILE: rtl/ev_charge_pilot_sequencer_top.sv
// ---------------------------------------------------------------------------
// ev_charge_pilot_sequencer_top
// control-pilot sequencer for one ac charging outlet
// ---------------------------------------------------------------------------
// Each transfer on cmd is a sequencer tick (opcode 0, with the sensed pilot
// level and supply-fault flags), a start command (1) or a stop command (2);
// opcode 3 changes nothing. Every item gives exactly one transfer on result,
// showing the charge state, outlet status, pwm enable and relay drive after
// the item, plus start-ok and stop-done pulses that can only be set on ticks.
// An item is registered on acceptance, passes through the next-state logic
// against the control-state register in the following cycle and lands in the
// result register once that is free; result valid thus follows the input and
// result registers. One item is taken every cycle while result is ready; the
// rate is set by the control-state update loop through ctl_q. A held result
// stalls cmd only once the input register is also occupied.
// ---------------------------------------------------------------------------
module ev_charge_pilot_sequencer_top (
	input  logic       clk,
	input  logic       arst_n,
	ecps_in_if.sink    cmd,
	ecps_out_if.source result
);
	import ecps_pkg::*;

	// input register
	in_item_t  item_s1;
	logic      valid_s1;

	// control state
	ctl_t      ctl_q;
	ctl_t      ctl_nxt;
	logic      start_ok;
	logic      stop_done;

	// handshake between the stages
	logic      out_free;
	logic      advance;
	out_item_t res;

	assign advance   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.opcode             <= cmd.opcode;
			item_s1.target_outlet      <= cmd.target_outlet;
			item_s1.pilot_level        <= cmd.pilot_level;
			item_s1.fault_undervoltage <= cmd.fault_undervoltage;
			item_s1.fault_overvoltage  <= cmd.fault_overvoltage;
			item_s1.fault_any          <= cmd.fault_any;
		end
	end

	ecps_step u_step (
		.item      (item_s1),
		.cur       (ctl_q),
		.nxt       (ctl_nxt),
		.start_ok  (start_ok),
		.stop_done (stop_done)
	);

	// control state commits when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.seq    <= ST_READY;
			ctl_q.status <= SC_NONE;
			ctl_q.pwm    <= 1'b0;
			ctl_q.relay  <= 1'b0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
		end
	end

	always_comb begin
		res.charge_state    = ctl_nxt.seq;
		res.outlet_status   = ctl_nxt.status;
		res.pwm_enable      = ctl_nxt.pwm;
		res.relay_closed    = ctl_nxt.relay;
		res.start_ok_pulse  = start_ok;
		res.stop_done_pulse = stop_done;
	end

	ecps_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.data   (res),
		.free   (out_free),
		.result (result)
	);

endmodule

FILE: rtl/ecps_chk.sv
// ---------------------------------------------------------------------------
// ecps_chk
// port-level checks for the charge pilot sequencer
// ---------------------------------------------------------------------------
`include "ev_charge_pilot_sequencer_top_defines.svh"

module ecps_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] charge_state,
	input logic [2:0] outlet_status,
	input logic       pwm_enable,
	input logic       relay_closed,
	input logic       start_ok_pulse,
	input logic       stop_done_pulse
);
	import ecps_pkg::*;

	`ECPS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped before transfer")

	`ECPS_ASSERT_NOW(a_relay_needs_pwm, res_valid && relay_closed, pwm_enable, "relay closed with pilot pwm off")

	`ECPS_ASSERT_NOW(a_start_ok, res_valid && start_ok_pulse, charge_state == ST_CHARGING && outlet_status == SC_WORKING && relay_closed, "start-ok pulse outside charging entry")

	`ECPS_ASSERT_NOW(a_stop_done, res_valid && stop_done_pulse, charge_state == ST_READY && outlet_status == SC_FINISHED && !pwm_enable && !relay_closed, "stop-done pulse with outlet not shut down")

endmodule

bind ev_charge_pilot_sequencer_top ecps_chk u_ecps_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.charge_state    (result.charge_state),
	.outlet_status   (result.outlet_status),
	.pwm_enable      (result.pwm_enable),
	.relay_closed    (result.relay_closed),
	.start_ok_pulse  (result.start_ok_pulse),
	.stop_done_pulse (result.stop_done_pulse)
);
